[hdl/rrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Field widths and fixed constants of the raid-5 request splitter.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 25;
  localparam int DISK_W      = 4;
  localparam int PLEN_W      = 20;
  localparam int NDISK_W     = 5;
  localparam int PIECE_LIMIT = 64;
  localparam int PIECE_W     = $clog2(PIECE_LIMIT);
  localparam int MIN_DISKS   = 3;

  localparam logic [DISK_W-1:0] DISK_COUNT_RESET = 4'd4;

endpackage

[hdl/raid5_request_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5_request_splitter
// Cuts a logical request into chunk pieces over a raid-5 array with rotating
// parity and gives disk, parity disk, disk offset and length for each piece.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. Its start chunk is divided
// by the data disk count with a shared one-bit-per-cycle restoring divider,
// which yields stripe, data index and parity disk in one pass over the
// ADDR_W - log2(CHUNK_BYTES) stripe bits of the offset. Then one piece is
// produced per cycle while the output register is free, up to 64 pieces,
// and the next request can be taken in the cycle after the last piece is
// registered. A zero-length request gives no piece and leaves the block
// idle. CHUNK_BYTES must be a power of two. disk_count is clamped to
// 3 .. MAX_DISKS for the mapping and must only be written while no request
// is in flight.
module raid5_request_splitter #(
  parameter int CHUNK_BYTES = 524288,
  parameter int MAX_DISKS   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rrs_pkg::DISK_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rrs_pkg::ADDR_W-1:0]        byte_offset,
  input  logic [rrs_pkg::LEN_W-1:0]         byte_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rrs_pkg::DISK_W-1:0]        data_disk,
  output logic [rrs_pkg::DISK_W-1:0]        parity_disk,
  output logic [rrs_pkg::ADDR_W-1:0]        disk_offset,
  output logic [rrs_pkg::PLEN_W-1:0]        piece_length,
  output logic                              last_piece
);

  localparam int CB   = $clog2(CHUNK_BYTES);
  localparam int SW   = rrs_pkg::ADDR_W - CB;
  localparam int CNTW = $clog2(SW + 1);
  localparam int LW   = (CB + 1 > rrs_pkg::LEN_W) ? CB + 1 : rrs_pkg::LEN_W;
  localparam int NW   = rrs_pkg::NDISK_W;
  localparam int DW   = rrs_pkg::DISK_W;

  localparam logic [NW-1:0] N_MIN = NW'(rrs_pkg::MIN_DISKS);
  localparam logic [NW-1:0] N_MAX = NW'(MAX_DISKS);
  localparam logic [LW-1:0] CHUNK = LW'(CHUNK_BYTES);

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_EMIT} state_t;

  state_t                       state;
  logic [DW-1:0]                disk_count;
  logic [NW-1:0]                n_eff;
  logic [DW-1:0]                d_eff;
  logic [SW-1:0]                acc;      // dividend, then quotient (stripe)
  logic [DW-1:0]                rem_d;    // running remainder, then data index
  logic [NW-1:0]                par;      // stripe mod n
  logic [CNTW-1:0]              step_cnt;
  logic [CB-1:0]                coff;
  logic [rrs_pkg::LEN_W-1:0]    rem_len;
  logic [rrs_pkg::PIECE_W-1:0]  piece_cnt;

  // clamped disk count for a new request
  logic [NW-1:0]                n_clamp;
  logic [rrs_pkg::ADDR_W:0]     end_full;
  logic [rrs_pkg::LEN_W-1:0]    len_clip;

  always_comb begin
    n_clamp = {1'b0, disk_count};
    if (n_clamp < N_MIN) n_clamp = N_MIN;
    if (n_clamp > N_MAX) n_clamp = N_MAX;
    end_full = {1'b0, byte_offset} + (rrs_pkg::ADDR_W + 1)'(byte_length);
    // end clipped at the top of the address space
    if (end_full[rrs_pkg::ADDR_W])
      len_clip = rrs_pkg::LEN_W'(~byte_offset + 1'b1);
    else
      len_clip = byte_length;
  end

  // shared divider step
  logic [DW:0]   div_try;
  logic          div_ge;
  logic [DW-1:0] div_r;
  logic [NW:0]   par_try;
  logic [NW-1:0] par_r;

  always_comb begin
    div_try = {rem_d, acc[SW-1]};
    div_ge  = div_try >= {1'b0, d_eff};
    div_r   = div_ge ? DW'(div_try - {1'b0, d_eff}) : div_try[DW-1:0];
    par_try = {par, div_ge};
    par_r   = (par_try >= {1'b0, n_eff}) ? NW'(par_try - {1'b0, n_eff})
                                         : par_try[NW-1:0];
  end

  // piece generation
  logic [LW-1:0] cap;
  logic [LW-1:0] plen;
  logic          last_c;
  logic [DW-1:0] disk_c;
  logic          load;
  logic [DW:0]   didx_inc;
  logic [NW-1:0] par_inc;

  always_comb begin
    cap      = CHUNK - LW'(coff);
    plen     = (cap < LW'(rem_len)) ? cap : LW'(rem_len);
    last_c   = (LW'(rem_len) == plen) ||
               (piece_cnt == rrs_pkg::PIECE_W'(rrs_pkg::PIECE_LIMIT - 1));
    disk_c   = ({1'b0, rem_d} < par) ? rem_d : DW'(rem_d + 1'b1);
    load     = (state == ST_EMIT) && (!out_valid || out_ready);
    didx_inc = {1'b0, rem_d} + 1'b1;
    par_inc  = par + 1'b1;
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      disk_count <= rrs_pkg::DISK_COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) disk_count <= cfg_data;

      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && byte_length != '0) begin
            n_eff     <= n_clamp;
            d_eff     <= DW'(n_clamp - 1'b1);
            acc       <= byte_offset[rrs_pkg::ADDR_W-1:CB];
            coff      <= byte_offset[CB-1:0];
            rem_len   <= len_clip;
            rem_d     <= '0;
            par       <= '0;
            step_cnt  <= CNTW'(SW);
            piece_cnt <= '0;
            state     <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          acc      <= {acc[SW-2:0], div_ge};
          rem_d    <= div_r;
          par      <= par_r;
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == CNTW'(1)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            data_disk    <= disk_c;
            parity_disk  <= par[DW-1:0];
            disk_offset  <= {acc, coff};
            piece_length <= plen[rrs_pkg::PLEN_W-1:0];
            last_piece   <= last_c;
            rem_len      <= rem_len - rrs_pkg::LEN_W'(plen);
            coff         <= '0;
            piece_cnt    <= piece_cnt + 1'b1;
            // step to the next chunk of the array
            if (didx_inc == {1'b0, d_eff}) begin
              rem_d <= '0;
              acc   <= acc + 1'b1;
              par   <= (par_inc == n_eff) ? '0 : par_inc;
            end else begin
              rem_d <= didx_inc[DW-1:0];
            end
            if (last_c) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
